@@ src/shs_pkg.sv @@
// Shared constants, item codes and types for the spline heightmap sampler.
// Used by shs_front, shs_queue, shs_back and the top level; depends on nothing.
package shs_pkg;

  localparam int NUM_POINTS  = 8;
  localparam int HEIGHT_BITS = 12;
  localparam int COLUMN_BITS = 12;
  localparam int WIDTH_BITS  = 13;
  localparam int INDEX_BITS  = 3;
  localparam int OUT_BITS    = 18;

  localparam int PTR_BITS  = $clog2(NUM_POINTS);
  localparam int SEG_BITS  = $clog2(NUM_POINTS - 1);
  localparam int POS_BITS  = PTR_BITS + 2;
  localparam int FRAC_BITS = 16;
  localparam int QUO_BITS  = SEG_BITS + FRAC_BITS;
  localparam int CNT_BITS  = $clog2(QUO_BITS);
  localparam int REM_BITS  = WIDTH_BITS + 1;
  localparam int PRODX_BITS = COLUMN_BITS + SEG_BITS;

  localparam int MUL_A_BITS = FRAC_BITS + 4;
  localparam int MUL_B_BITS = (HEIGHT_BITS + 1 > FRAC_BITS + 1) ? HEIGHT_BITS + 1
                                                                : FRAC_BITS + 1;
  localparam int ACC_BITS   = MUL_A_BITS + MUL_B_BITS;
  localparam int ROUND_SHIFT = FRAC_BITS - 3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(1024);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_EVAL  = 2'd1;
  localparam logic [1:0] KIND_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]             kind;
    logic [INDEX_BITS-1:0]  index;
    logic [HEIGHT_BITS-1:0] height;
    logic [COLUMN_BITS-1:0] column;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

@@ src/spline_heightmap_sampler_unit.sv @@
// Top level of the spline heightmap sampler: front end, item queue, back end.
// Depends on shs_pkg, shs_front, shs_queue and shs_back.
//
//   channel   handshake            payload
//   command   start / busy         operation, point_index, point_height, column
//   result    done (strobe)        height_q4, out_of_range
//   config    cfg_valid/cfg_ready  cfg_data (screen width)
//
// An evaluate item holds the back end while it runs the restoring divider, one
// quotient bit a cycle, then 9 steps for the powers of t, the weights, four
// products through the single shared multiplier, the sum and the rounding; done
// strobes in the cycle after. A write updates the control points when it is taken;
// an out-of-range column is taken with done strobing in the next cycle.
// Items pass through a two-beat queue, so busy rises only when it is full.
// Reset clears the control points to zero and sets the width to 1024.
// Results are strobed for one cycle and cannot be held off.
module spline_heightmap_sampler_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  operation,
  input  logic [shs_pkg::INDEX_BITS-1:0]        point_index,
  input  logic [shs_pkg::HEIGHT_BITS-1:0]       point_height,
  input  logic [shs_pkg::COLUMN_BITS-1:0]       column,
  output logic                                  done,
  output logic signed [shs_pkg::OUT_BITS-1:0]   height_q4,
  output logic                                  out_of_range,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [shs_pkg::WIDTH_BITS-1:0]        cfg_data
);

  shs_pkg::qstat_t                   qstat;
  shs_pkg::item_t                    push_item;
  shs_pkg::item_t                    head;
  logic                              push;
  logic                              pop;
  logic [shs_pkg::WIDTH_BITS-1:0]    screen_width;

  shs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .point_index  (point_index),
    .point_height (point_height),
    .column       (column),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .qstat        (qstat),
    .push         (push),
    .push_item    (push_item),
    .screen_width (screen_width)
  );

  shs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (head),
    .qstat     (qstat)
  );

  shs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .qstat        (qstat),
    .screen_width (screen_width),
    .pop          (pop),
    .done         (done),
    .height_q4    (height_q4),
    .out_of_range (out_of_range)
  );

endmodule

@@ src/shs_front.sv @@
// Front end: command handshake, width register and item classification.
// Depends on shs_pkg; feeds shs_queue.
module shs_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                operation,
  input  logic [shs_pkg::INDEX_BITS-1:0]      point_index,
  input  logic [shs_pkg::HEIGHT_BITS-1:0]     point_height,
  input  logic [shs_pkg::COLUMN_BITS-1:0]     column,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [shs_pkg::WIDTH_BITS-1:0]      cfg_data,
  input  shs_pkg::qstat_t                     qstat,
  output logic                                push,
  output shs_pkg::item_t                      push_item,
  output logic [shs_pkg::WIDTH_BITS-1:0]      screen_width
);

  logic in_range;

  assign cfg_ready = 1'b1;
  assign busy      = qstat.full;
  assign push      = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width <= shs_pkg::WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      screen_width <= cfg_data;
    end
  end

  assign in_range = (shs_pkg::WIDTH_BITS + 1)'(column) <
                    (shs_pkg::WIDTH_BITS + 1)'(screen_width);

  always_comb begin
    push_item.index  = point_index;
    push_item.height = point_height;
    push_item.column = column;
    if (operation == shs_pkg::OP_WRITE) begin
      push_item.kind = shs_pkg::KIND_WRITE;
    end else if (in_range) begin
      push_item.kind = shs_pkg::KIND_EVAL;
    end else begin
      push_item.kind = shs_pkg::KIND_RANGE;
    end
  end

endmodule

@@ src/shs_queue.sv @@
// Short item queue between the front end and the back end.
// Depends on shs_pkg.
module shs_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  shs_pkg::item_t  push_item,
  input  logic            pop,
  output shs_pkg::item_t  pop_item,
  output shs_pkg::qstat_t qstat
);

  shs_pkg::item_t                  q_mem [shs_pkg::QUEUE_DEPTH];
  logic [shs_pkg::QPTR_BITS-1:0]   wr_ptr;
  logic [shs_pkg::QPTR_BITS-1:0]   rd_ptr;
  logic [shs_pkg::QPTR_BITS:0]     count;
  logic                            do_push;
  logic                            do_pop;

  assign qstat.full  = count == (shs_pkg::QPTR_BITS + 1)'(shs_pkg::QUEUE_DEPTH);
  assign qstat.empty = count == '0;
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign pop_item    = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == shs_pkg::QPTR_BITS'(shs_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == shs_pkg::QPTR_BITS'(shs_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ src/shs_back.sv @@
// Back end: control-point store, restoring divider and shared-multiplier blend.
// Depends on shs_pkg; drains shs_queue.
module shs_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  shs_pkg::item_t                        head,
  input  shs_pkg::qstat_t                       qstat,
  input  logic [shs_pkg::WIDTH_BITS-1:0]        screen_width,
  output logic                                  pop,
  output logic                                  done,
  output logic signed [shs_pkg::OUT_BITS-1:0]   height_q4,
  output logic                                  out_of_range
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;

  localparam logic [3:0] S_SQ   = 4'd0;
  localparam logic [3:0] S_CUBE = 4'd1;
  localparam logic [3:0] S_WGT  = 4'd2;
  localparam logic [3:0] S_P0   = 4'd3;
  localparam logic [3:0] S_P1   = 4'd4;
  localparam logic [3:0] S_P2   = 4'd5;
  localparam logic [3:0] S_P3   = 4'd6;
  localparam logic [3:0] S_ACC  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  localparam int FB = shs_pkg::FRAC_BITS;
  localparam int AB = shs_pkg::MUL_A_BITS;
  localparam int BB = shs_pkg::MUL_B_BITS;
  localparam int CB = shs_pkg::ACC_BITS;
  localparam int PB = shs_pkg::POS_BITS;

  localparam logic signed [AB-1:0] W_TWO    = AB'(2 << FB);
  localparam logic signed [PB-1:0] LAST_POS = PB'(shs_pkg::NUM_POINTS - 1);
  localparam logic signed [CB-1:0] HALF_LSB = CB'(1 << (shs_pkg::ROUND_SHIFT - 1));
  localparam logic signed [CB-1:0] SAT_HI   = CB'((1 << (shs_pkg::OUT_BITS - 1)) - 1);
  localparam logic signed [CB-1:0] SAT_LO   = ~SAT_HI;

  logic [shs_pkg::HEIGHT_BITS-1:0] heights [shs_pkg::NUM_POINTS];

  logic [1:0]                        state;
  logic [3:0]                        step;
  logic [shs_pkg::CNT_BITS-1:0]      cnt;
  logic [shs_pkg::REM_BITS-1:0]      rem;
  logic [shs_pkg::QUO_BITS-1:0]      dq;
  logic [FB-1:0]                     t2;
  logic signed [AB-1:0]              w0, w1, w2, w3;
  logic signed [CB-1:0]              m;
  logic signed [CB-1:0]              acc;

  logic [shs_pkg::PRODX_BITS-1:0]    prodx;
  logic [shs_pkg::REM_BITS-1:0]      rem_shift;
  logic                              ge;
  logic [shs_pkg::SEG_BITS-1:0]      seg;
  logic [FB-1:0]                     frac_t;
  logic [FB-1:0]                     t3;
  logic signed [AB-1:0]              et, et2, et3;
  logic signed [AB-1:0]              mul_a;
  logic signed [BB-1:0]              mul_b;
  logic signed [CB-1:0]              m_next;
  logic signed [PB-1:0]              pos;
  logic [shs_pkg::PTR_BITS-1:0]      pidx;
  logic signed [BB-1:0]              point;
  logic signed [CB-1:0]              rnd;
  logic signed [CB-1:0]              q;

  assign pop = (state == ST_IDLE) && !qstat.empty;

  assign prodx = shs_pkg::PRODX_BITS'(shs_pkg::NUM_POINTS - 1) *
                 shs_pkg::PRODX_BITS'(head.column);

  assign rem_shift = {rem[shs_pkg::REM_BITS-2:0], dq[shs_pkg::QUO_BITS-1]};
  assign ge        = rem_shift >= {1'b0, screen_width};

  assign seg    = dq[shs_pkg::QUO_BITS-1:FB];
  assign frac_t = dq[FB-1:0];
  assign t3     = m[2*FB-1:FB];

  assign et  = $signed({{(AB - FB){1'b0}}, frac_t});
  assign et2 = $signed({{(AB - FB){1'b0}}, t2});
  assign et3 = $signed({{(AB - FB){1'b0}}, t3});

  always_comb begin
    pos = PB'(seg) + PB'(step) - PB'(S_P1);
    if (pos < 0) begin
      pidx = '0;
    end else if (pos > LAST_POS) begin
      pidx = shs_pkg::PTR_BITS'(shs_pkg::NUM_POINTS - 1);
    end else begin
      pidx = shs_pkg::PTR_BITS'(pos);
    end
    point = $signed({{(BB - shs_pkg::HEIGHT_BITS){1'b0}}, heights[pidx]});
  end

  always_comb begin
    mul_a = et;
    mul_b = BB'(et);
    unique case (step)
      S_SQ: begin
        mul_a = et;
        mul_b = BB'(et);
      end
      S_CUBE: begin
        mul_a = $signed({{(AB - FB){1'b0}}, m[2*FB-1:FB]});
        mul_b = BB'(et);
      end
      S_P0: begin
        mul_a = w0;
        mul_b = point;
      end
      S_P1: begin
        mul_a = w1;
        mul_b = point;
      end
      S_P2: begin
        mul_a = w2;
        mul_b = point;
      end
      S_P3: begin
        mul_a = w3;
        mul_b = point;
      end
      default: begin
        mul_a = et;
        mul_b = BB'(et);
      end
    endcase
    m_next = mul_a * mul_b;
  end

  assign rnd = acc + HALF_LSB;
  assign q   = rnd >>> shs_pkg::ROUND_SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < shs_pkg::NUM_POINTS; i++) begin
        heights[i] <= '0;
      end
    end else if (pop && head.kind == shs_pkg::KIND_WRITE &&
                 32'(head.index) < shs_pkg::NUM_POINTS) begin
      heights[shs_pkg::PTR_BITS'(head.index)] <= head.height;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= S_SQ;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            unique case (head.kind)
              shs_pkg::KIND_EVAL: begin
                rem   <= shs_pkg::REM_BITS'(prodx >> shs_pkg::SEG_BITS);
                dq    <= {prodx[shs_pkg::SEG_BITS-1:0], {FB{1'b0}}};
                cnt   <= '0;
                state <= ST_DIV;
              end
              shs_pkg::KIND_RANGE: begin
                done         <= 1'b1;
                out_of_range <= 1'b1;
                height_q4    <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_DIV: begin
          rem <= ge ? rem_shift - {1'b0, screen_width} : rem_shift;
          dq  <= {dq[shs_pkg::QUO_BITS-2:0], ge};
          cnt <= cnt + 1'b1;
          if (cnt == shs_pkg::CNT_BITS'(shs_pkg::QUO_BITS - 1)) begin
            step  <= S_SQ;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          step <= step + 1'b1;
          unique case (step)
            S_SQ: begin
              m <= m_next;
            end
            S_CUBE: begin
              t2 <= m[2*FB-1:FB];
              m  <= m_next;
            end
            S_WGT: begin
              w0 <= -et3 + (et2 <<< 1) - et;
              w1 <= et3 + (et3 <<< 1) - et2 - (et2 <<< 2) + W_TWO;
              w2 <= -et3 - (et3 <<< 1) + (et2 <<< 2) + et;
              w3 <= et3 - et2;
            end
            S_P0: begin
              m <= m_next;
            end
            S_P1: begin
              acc <= m;
              m   <= m_next;
            end
            S_P2, S_P3: begin
              acc <= acc + m;
              m   <= m_next;
            end
            S_ACC: begin
              acc <= acc + m;
            end
            S_OUT: begin
              done         <= 1'b1;
              out_of_range <= 1'b0;
              if (q > SAT_HI) begin
                height_q4 <= shs_pkg::OUT_BITS'(SAT_HI);
              end else if (q < SAT_LO) begin
                height_q4 <= shs_pkg::OUT_BITS'(SAT_LO);
              end else begin
                height_q4 <= shs_pkg::OUT_BITS'(q);
              end
              state <= ST_IDLE;
            end
            default: begin
              state <= ST_IDLE;
            end
          endcase
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for spline_heightmap_sampler_unit: directed rows, then random
// command beats over a range of screen widths, checked against a Catmull-Rom predictor or pinned values.
// Depends on shs_pkg and the RTL of the sampler only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import shs_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int QUIET_LIMIT   = 3000;
  localparam int PHASES        = 9;
  localparam int PHASE_ITEMS   = 50;
  localparam int PLAN_ROWS     = 25;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] height;
    logic                       oor;
  } sample_t;

  typedef struct packed {
    logic                       op;
    logic [INDEX_BITS-1:0]      idx;
    logic [HEIGHT_BITS-1:0]     hgt;
    logic [COLUMN_BITS-1:0]     col;
    logic                       pinned;
    logic signed [OUT_BITS-1:0] q;
    logic                       oor;
  } plan_row_t;

  logic                        clk;
  logic                        rst;
  logic                        start;
  logic                        busy;
  logic                        operation;
  logic [INDEX_BITS-1:0]       point_index;
  logic [HEIGHT_BITS-1:0]      point_height;
  logic [COLUMN_BITS-1:0]      column;
  logic                        done;
  logic signed [OUT_BITS-1:0]  height_q4;
  logic                        out_of_range;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [WIDTH_BITS-1:0]       cfg_data;

  logic                        pin_valid;
  logic signed [OUT_BITS-1:0]  pin_height;
  logic                        pin_oor;

  int      point_mem [NUM_POINTS];
  int      span_width;
  sample_t pending_samples [$];
  int      fails;
  int      quiet;
  int      n_writes;
  int      n_evals;
  int      n_oor;
  int      n_below;
  int      n_widths;

  plan_row_t plan [PLAN_ROWS] = '{
    '{OP_EVAL,  3'd0, 12'd0,    12'd0,    1'b1, 18'sd0,     1'b0},
    '{OP_EVAL,  3'd0, 12'd0,    12'd1023, 1'b1, 18'sd0,     1'b0},
    '{OP_EVAL,  3'd0, 12'd0,    12'd1024, 1'b1, 18'sd0,     1'b1},
    '{OP_EVAL,  3'd0, 12'd0,    12'd4095, 1'b1, 18'sd0,     1'b1},
    '{OP_WRITE, 3'd0, 12'd4095, 12'd0,    1'b0, 18'sd0,     1'b0},
    '{OP_WRITE, 3'd1, 12'd4095, 12'd0,    1'b0, 18'sd0,     1'b0},
    '{OP_WRITE, 3'd2, 12'd4095, 12'd0,    1'b0, 18'sd0,     1'b0},
    '{OP_WRITE, 3'd3, 12'd4095, 12'd0,    1'b0, 18'sd0,     1'b0},
    '{OP_WRITE, 3'd4, 12'd4095, 12'd0,    1'b0, 18'sd0,     1'b0},
    '{OP_WRITE, 3'd5, 12'd4095, 12'd0,    1'b0, 18'sd0,     1'b0},
    '{OP_WRITE, 3'd6, 12'd4095, 12'd0,    1'b0, 18'sd0,     1'b0},
    '{OP_WRITE, 3'd7, 12'd4095, 12'd0,    1'b0, 18'sd0,     1'b0},
    '{OP_EVAL,  3'd0, 12'd0,    12'd0,    1'b1, 18'sd65520, 1'b0},
    '{OP_EVAL,  3'd0, 12'd0,    12'd512,  1'b1, 18'sd65520, 1'b0},
    '{OP_EVAL,  3'd0, 12'd0,    12'd1023, 1'b1, 18'sd65520, 1'b0},
    '{OP_WRITE, 3'd0, 12'd0,    12'd0,    1'b0, 18'sd0,     1'b0},
    '{OP_WRITE, 3'd7, 12'd0,    12'd0,    1'b0, 18'sd0,     1'b0},
    '{OP_WRITE, 3'd3, 12'd2730, 12'd0,    1'b0, 18'sd0,     1'b0},
    '{OP_WRITE, 3'd4, 12'd1365, 12'd0,    1'b0, 18'sd0,     1'b0},
    '{OP_EVAL,  3'd0, 12'd0,    12'd1,    1'b0, 18'sd0,     1'b0},
    '{OP_EVAL,  3'd0, 12'd0,    12'd146,  1'b0, 18'sd0,     1'b0},
    '{OP_EVAL,  3'd0, 12'd0,    12'd147,  1'b0, 18'sd0,     1'b0},
    '{OP_EVAL,  3'd0, 12'd0,    12'd585,  1'b0, 18'sd0,     1'b0},
    '{OP_EVAL,  3'd0, 12'd0,    12'd800,  1'b0, 18'sd0,     1'b0},
    '{OP_EVAL,  3'd0, 12'd4095, 12'd1023, 1'b0, 18'sd0,     1'b0}
  };

  int phase_width [PHASES] = '{2, 4096, 1, 8191, 0, 1024, 700, 0, 0};

  spline_heightmap_sampler_unit dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .point_index  (point_index),
    .point_height (point_height),
    .column       (column),
    .done         (done),
    .height_q4    (height_q4),
    .out_of_range (out_of_range),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic sample_t sample_height(input int col);
    sample_t r;
    longint  w, prod, seg, rem, t1, t2, t3, w0, w1, w2, w3, s, x, q;
    r.height = '0;
    r.oor    = 1'b0;
    if (col >= span_width) begin
      r.oor = 1'b1;
      return r;
    end
    w    = span_width;
    prod = (NUM_POINTS - 1) * longint'(col);
    seg  = prod / w;
    if (seg > NUM_POINTS - 2) seg = NUM_POINTS - 2;
    rem = prod - seg * w;
    if (rem >= w) rem = w - 1;
    t1 = (rem << 16) / w;
    t2 = (t1 * t1) >> 16;
    t3 = (t2 * t1) >> 16;
    w0 = -t3 + 2 * t2 - t1;
    w1 = 3 * t3 - 5 * t2 + 2 * 65536;
    w2 = -3 * t3 + 4 * t2 + t1;
    w3 = t3 - t2;
    s = w0 * point_mem[(seg == 0) ? 0 : seg - 1] + w1 * point_mem[seg]
      + w2 * point_mem[seg + 1]
      + w3 * point_mem[(seg + 2 > NUM_POINTS - 1) ? NUM_POINTS - 1 : seg + 2];
    x = s + 4096;
    if (x >= 0) q = x / 8192;
    else q = -((-x + 8191) / 8192);
    if (q > 131071) q = 131071;
    if (q < -131072) q = -131072;
    r.height = q[OUT_BITS-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    sample_t got;
    if (!rst) begin
      if (done) begin
        if (pending_samples.size() == 0) begin
          $error("unexpected result beat: height_q4 %0d out_of_range %0d",
                 height_q4, out_of_range);
          fails++;
        end else begin
          got = pending_samples.pop_front();
          if (height_q4 !== got.height) begin
            $error("height_q4: expected %0d, actual %0d", got.height, height_q4);
            fails++;
          end
          if (out_of_range !== got.oor) begin
            $error("out_of_range: expected %0d, actual %0d", got.oor, out_of_range);
            fails++;
          end
        end
      end
      if (start && !busy) begin
        if (operation == OP_WRITE) begin
          point_mem[point_index] = int'(point_height);
          n_writes++;
        end else begin
          got = sample_height(int'(column));
          if (pin_valid) begin
            got.height = pin_height;
            got.oor    = pin_oor;
          end
          pending_samples.push_back(got);
          n_evals++;
          if (got.oor) n_oor++;
          if (got.height[OUT_BITS-1]) n_below++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        span_width = int'(cfg_data);
        n_widths++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("** spline_heightmap_sampler_unit: FAILED **");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic wait_drained();
    @(negedge clk);
    while (pending_samples.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic hold_off(input int gap, input bit drain);
    if (gap != 0 || drain) start <= 1'b0;
    if (drain) wait_drained();
    repeat (gap) @(posedge clk);
  endtask

  task automatic send_item(input logic op, input logic [INDEX_BITS-1:0] idx,
                           input logic [HEIGHT_BITS-1:0] hgt,
                           input logic [COLUMN_BITS-1:0] col, input logic pin,
                           input logic signed [OUT_BITS-1:0] q, input logic oor);
    start        <= 1'b1;
    operation    <= op;
    point_index  <= idx;
    point_height <= hgt;
    column       <= col;
    pin_valid    <= pin;
    pin_height   <= q;
    pin_oor      <= oor;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic set_width(input logic [WIDTH_BITS-1:0] w);
    start <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int          gap;
    int          w;
    int          lim;
    int          sel;
    logic        op;
    logic [HEIGHT_BITS-1:0] hgt;
    logic [COLUMN_BITS-1:0] col;
    rst          = 1'b1;
    start        = 1'b0;
    operation    = OP_WRITE;
    point_index  = '0;
    point_height = '0;
    column       = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    pin_valid    = 1'b0;
    pin_height   = '0;
    pin_oor      = 1'b0;
    fails        = 0;
    n_writes     = 0;
    n_evals      = 0;
    n_oor        = 0;
    n_below      = 0;
    n_widths     = 0;
    span_width   = int'(WIDTH_RESET);
    foreach (point_mem[k]) point_mem[k] = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[r]) begin
      hold_off($urandom_range(0, 18), 1'b0);
      send_item(plan[r].op, plan[r].idx, plan[r].hgt, plan[r].col, plan[r].pinned,
                plan[r].q, plan[r].oor);
    end

    for (int p = 0; p < PHASES; p++) begin
      w = (p >= 7) ? int'($urandom_range(2, 4096)) : phase_width[p];
      set_width(WIDTH_BITS'(w));
      lim = (w == 0) ? 0 : ((w > 4096) ? 4095 : w - 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p % 2 == 1) gap = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 18) : 0;
        else gap = $urandom_range(0, 18);
        hold_off(gap, (p == 3 && i == 20));
        op  = ($urandom_range(0, 9) < 3) ? OP_WRITE : OP_EVAL;
        sel = $urandom_range(0, 9);
        hgt = (sel == 0) ? '0 : (sel == 1) ? '1 : HEIGHT_BITS'($urandom);
        sel = $urandom_range(0, 9);
        case (sel)
          0: col = '0;
          1: col = COLUMN_BITS'(lim);
          2: col = COLUMN_BITS'((w <= 4095) ? w : int'($urandom_range(0, 4095)));
          3: col = COLUMN_BITS'($urandom_range(0, 4095));
          default: col = COLUMN_BITS'($urandom_range(0, lim));
        endcase
        send_item(op, INDEX_BITS'($urandom_range(0, NUM_POINTS - 1)), hgt, col, 1'b0,
                  '0, 1'b0);
      end
    end

    start <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d point writes and %0d evaluations (%0d out of range, %0d below zero)",
             n_writes, n_evals, n_oor, n_below);
    $display("across %0d screen width settings including 0, 1, 2, 4096 and 8191", n_widths);
    if (fails == 0) begin
      $display("** spline_heightmap_sampler_unit: PASSED **");
    end else begin
      $display("** spline_heightmap_sampler_unit: FAILED **");
    end
    $finish;
  end

endmodule
